FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared widths, constants, register indexes and the calibration record.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int CAL_W  = 16;

  // Payload widths
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 20;
  localparam int PRES_W = 32;

  // Raw value that marks a failed conversion, besides zero.
  localparam logic [RAW_W-1:0] RAW_ALL_ONES = {RAW_W{1'b1}};

  // Temperature thresholds in 0.01 degC
  localparam int TEMP_REF      = 2000;
  localparam int TEMP_VERY_LOW = -1500;

  // Datapath widths
  localparam int DT_W    = 25;  // raw temperature minus reference
  localparam int MT_W    = 42;  // dT times a 16-bit coefficient
  localparam int DD_W    = 50;  // dT squared
  localparam int Q_W     = 19;  // temperature minus the reference point
  localparam int T2_W    = 19;  // second-order temperature term
  localparam int SQ_W    = 36;  // squared temperature distances
  localparam int M_W     = 38;  // small multiples of those squares
  localparam int CORR_W  = 39;  // second-order offset and sensitivity terms
  localparam int OFF_W   = 40;  // offset
  localparam int SENS_W  = 40;  // sensitivity
  localparam int SPLIT   = 20;  // split point of the sensitivity multiply
  localparam int LO_W    = RAW_W + SPLIT;
  localparam int HI_W    = RAW_W + 1 + SENS_W - SPLIT;
  localparam int PROD_W  = 64;
  localparam int DIFF_W  = 48;

  // Fixed-point shifts
  localparam int T_SHIFT    = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;

  // Very-low threshold relative to the reference point.
  localparam logic signed [Q_W-1:0] Q_VERY_LOW = Q_W'(TEMP_VERY_LOW - TEMP_REF);

  // Pipeline depth, output register included.
  localparam int NS = 10;

  typedef enum logic [2:0] {
    REG_PRESS_SENS = 3'd0,
    REG_PRESS_OFS  = 3'd1,
    REG_SENS_TCO   = 3'd2,
    REG_OFS_TCO    = 3'd3,
    REG_TEMP_REF   = 3'd4,
    REG_TEMP_COEF  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coef;
  } cal_t;

endpackage

FILE: rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// Barometer compensation stream interfaces
// Valid/ready channels for raw sample pairs and for compensated results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  import bpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centideg;
  logic signed [PRES_W-1:0] pressure_pa;
  logic                     sample_error;

  modport source (output valid, output temperature_centideg, output pressure_pa,
                  output sample_error, input ready);
  modport sink   (input valid, input temperature_centideg, input pressure_pa,
                  input sample_error, output ready);
endinterface

FILE: rtl/bpc_regs.sv
// ----------------------------------------------------------------------------
// Barometer compensation calibration registers
// APB-style register file holding the six 16-bit calibration words.
// ----------------------------------------------------------------------------
module bpc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bpc_pkg::cal_t               cal_o
);
  import bpc_pkg::*;

  cal_t     cal_q;
  cal_t     cal_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cal_o  = cal_q;

  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      case (idx)
        REG_PRESS_SENS: cal_d.pressure_sensitivity  = pwdata[CAL_W-1:0];
        REG_PRESS_OFS:  cal_d.pressure_offset       = pwdata[CAL_W-1:0];
        REG_SENS_TCO:   cal_d.sensitivity_temp_coef = pwdata[CAL_W-1:0];
        REG_OFS_TCO:    cal_d.offset_temp_coef      = pwdata[CAL_W-1:0];
        REG_TEMP_REF:   cal_d.reference_temperature = pwdata[CAL_W-1:0];
        REG_TEMP_COEF:  cal_d.temperature_coef      = pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRESS_SENS: prdata = DATA_W'(cal_q.pressure_sensitivity);
      REG_PRESS_OFS:  prdata = DATA_W'(cal_q.pressure_offset);
      REG_SENS_TCO:   prdata = DATA_W'(cal_q.sensitivity_temp_coef);
      REG_OFS_TCO:    prdata = DATA_W'(cal_q.offset_temp_coef);
      REG_TEMP_REF:   prdata = DATA_W'(cal_q.reference_temperature);
      REG_TEMP_COEF:  prdata = DATA_W'(cal_q.temperature_coef);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

endmodule

FILE: rtl/baro_pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// Barometer pressure and temperature compensation
// Ten-stage pipeline turning raw conversions into 0.01 degC and Pa.
// ----------------------------------------------------------------------------
// The block takes one raw pressure/temperature pair per cycle unless an output
// stall has filled every stage, and returns one result per pair, in order. The
// ten register stages are the dT subtraction, the coefficient products, the
// first-order terms, the squaring for the cold corrections, two stages of
// correction sums, the final offset and sensitivity, the pressure multiply
// split into two 24 x 20 bit partial products, their sum, and the output register.
// A stall on the output holds only the run of full stages in front of it, so empty
// stages still fill while a result waits. Calibration words are read by each
// item as it passes; write them only while no item is in flight.
module baro_pressure_temperature_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  bpc_in_if.sink                     in_if,
  bpc_out_if.source                  out_if
);
  import bpc_pkg::*;

  cal_t cal;

  bpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  // --------------------------------------------------------------------------
  // Pipeline control: a stage moves on when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  logic [NS:1] v_q;
  logic [NS:1] v_prev;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_q[NS] || out_if.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_prev      = {v_q[NS-1:1], in_if.valid};
  assign in_if.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_prev) | (~en & v_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: dT and sample check
  // --------------------------------------------------------------------------
  logic signed [DT_W-1:0]  s1_dt_d, s1_dt_q;
  logic                    s1_err_d, s1_err_q;
  logic [RAW_W-1:0]        s1_d1_q;

  assign s1_dt_d  = DT_W'(in_if.raw_temperature) - DT_W'({cal.reference_temperature, 8'h00});
  assign s1_err_d = (in_if.raw_pressure == '0) || (in_if.raw_pressure == RAW_ALL_ONES) ||
                    (in_if.raw_temperature == '0) || (in_if.raw_temperature == RAW_ALL_ONES);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_dt_q  <= s1_dt_d;
      s1_err_q <= s1_err_d;
      s1_d1_q  <= in_if.raw_pressure;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dT products
  // --------------------------------------------------------------------------
  logic signed [MT_W-1:0] s2_mt_d, s2_mt_q;
  logic signed [MT_W-1:0] s2_mo_d, s2_mo_q;
  logic signed [MT_W-1:0] s2_ms_d, s2_ms_q;
  logic signed [DD_W-1:0] s2_dd_d, s2_dd_q;
  logic                   s2_err_q;
  logic [RAW_W-1:0]       s2_d1_q;

  assign s2_mt_d = MT_W'(s1_dt_q) * MT_W'($signed({1'b0, cal.temperature_coef}));
  assign s2_mo_d = MT_W'(s1_dt_q) * MT_W'($signed({1'b0, cal.offset_temp_coef}));
  assign s2_ms_d = MT_W'(s1_dt_q) * MT_W'($signed({1'b0, cal.sensitivity_temp_coef}));
  assign s2_dd_d = DD_W'(s1_dt_q) * DD_W'(s1_dt_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_mt_q  <= s2_mt_d;
      s2_mo_q  <= s2_mo_d;
      s2_ms_q  <= s2_ms_d;
      s2_dd_q  <= s2_dd_d;
      s2_err_q <= s1_err_q;
      s2_d1_q  <= s1_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: first-order terms; temperature kept relative to 20.00 degC
  // --------------------------------------------------------------------------
  logic signed [Q_W-1:0]    s3_q_d, s3_q_q;
  logic signed [Q_W-1:0]    s3_dvl_d, s3_dvl_q;
  logic                     s3_low_d, s3_low_q;
  logic                     s3_vlow_d, s3_vlow_q;
  logic signed [OFF_W-1:0]  s3_off_d, s3_off_q;
  logic signed [SENS_W-1:0] s3_sens_d, s3_sens_q;
  logic [T2_W-1:0]          s3_t2_d, s3_t2_q;
  logic                     s3_err_q;
  logic [RAW_W-1:0]         s3_d1_q;

  assign s3_q_d    = Q_W'(s2_mt_q >>> T_SHIFT);
  assign s3_low_d  = s3_q_d[Q_W-1];
  assign s3_vlow_d = s3_q_d < Q_VERY_LOW;
  assign s3_dvl_d  = s3_q_d - Q_VERY_LOW;
  assign s3_off_d  = OFF_W'({cal.pressure_offset, 16'h0000}) + OFF_W'(s2_mo_q >>> OFF_SHIFT);
  assign s3_sens_d = SENS_W'({cal.pressure_sensitivity, 15'h0000})
                   + SENS_W'(s2_ms_q >>> SENS_SHIFT);
  assign s3_t2_d   = T2_W'(s2_dd_q >>> T2_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_q_q    <= s3_q_d;
      s3_dvl_q  <= s3_dvl_d;
      s3_low_q  <= s3_low_d;
      s3_vlow_q <= s3_vlow_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_t2_q   <= s3_t2_d;
      s3_err_q  <= s2_err_q;
      s3_d1_q   <= s2_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared distances and final temperature
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]          s4_sq1_d, s4_sq1_q;
  logic [SQ_W-1:0]          s4_sq2_d, s4_sq2_q;
  logic signed [TEMP_W-1:0] s4_temp_d, s4_temp_q;
  logic                     s4_low_q, s4_vlow_q;
  logic signed [OFF_W-1:0]  s4_off_q;
  logic signed [SENS_W-1:0] s4_sens_q;
  logic                     s4_err_q;
  logic [RAW_W-1:0]         s4_d1_q;

  assign s4_sq1_d  = SQ_W'(s3_q_q) * SQ_W'(s3_q_q);
  assign s4_sq2_d  = SQ_W'(s3_dvl_q) * SQ_W'(s3_dvl_q);
  assign s4_temp_d = TEMP_W'(TEMP_REF) + TEMP_W'(s3_q_q)
                   - (s3_low_q ? TEMP_W'(s3_t2_q) : TEMP_W'(0));

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_sq1_q  <= s4_sq1_d;
      s4_sq2_q  <= s4_sq2_d;
      s4_temp_q <= s4_temp_d;
      s4_low_q  <= s3_low_q;
      s4_vlow_q <= s3_vlow_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_err_q  <= s3_err_q;
      s4_d1_q   <= s3_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: multiples of the squares, zero where the correction is off
  // --------------------------------------------------------------------------
  logic [M_W-1:0]           s5_five_d, s5_five_q;
  logic [M_W-1:0]           s5_seven_d, s5_seven_q;
  logic [M_W-1:0]           s5_eleven_d, s5_eleven_q;
  logic signed [TEMP_W-1:0] s5_temp_q;
  logic signed [OFF_W-1:0]  s5_off_q;
  logic signed [SENS_W-1:0] s5_sens_q;
  logic                     s5_err_q;
  logic [RAW_W-1:0]         s5_d1_q;

  assign s5_five_d   = s4_low_q  ? M_W'(s4_sq1_q) + (M_W'(s4_sq1_q) << 2) : '0;
  assign s5_seven_d  = s4_vlow_q ? (M_W'(s4_sq2_q) << 3) - M_W'(s4_sq2_q) : '0;
  assign s5_eleven_d = s4_vlow_q ? (M_W'(s4_sq2_q) << 3) + (M_W'(s4_sq2_q) << 1)
                                   + M_W'(s4_sq2_q) : '0;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_five_q   <= s5_five_d;
      s5_seven_q  <= s5_seven_d;
      s5_eleven_q <= s5_eleven_d;
      s5_temp_q   <= s4_temp_q;
      s5_off_q    <= s4_off_q;
      s5_sens_q   <= s4_sens_q;
      s5_err_q    <= s4_err_q;
      s5_d1_q     <= s4_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: second-order offset and sensitivity terms
  // --------------------------------------------------------------------------
  logic [CORR_W-1:0]        s6_off2_d, s6_off2_q;
  logic [CORR_W-1:0]        s6_sens2_d, s6_sens2_q;
  logic signed [TEMP_W-1:0] s6_temp_q;
  logic signed [OFF_W-1:0]  s6_off_q;
  logic signed [SENS_W-1:0] s6_sens_q;
  logic                     s6_err_q;
  logic [RAW_W-1:0]         s6_d1_q;

  // Each multiple is floored on its own before the terms are summed.
  assign s6_off2_d  = CORR_W'(s5_five_q >> 1) + CORR_W'(s5_seven_q);
  assign s6_sens2_d = CORR_W'(s5_five_q >> 2) + CORR_W'(s5_eleven_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_off2_q  <= s6_off2_d;
      s6_sens2_q <= s6_sens2_d;
      s6_temp_q  <= s5_temp_q;
      s6_off_q   <= s5_off_q;
      s6_sens_q  <= s5_sens_q;
      s6_err_q   <= s5_err_q;
      s6_d1_q    <= s5_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: corrected offset and sensitivity
  // --------------------------------------------------------------------------
  logic signed [OFF_W-1:0]  s7_off_d, s7_off_q;
  logic signed [SENS_W-1:0] s7_sens_d, s7_sens_q;
  logic signed [TEMP_W-1:0] s7_temp_q;
  logic                     s7_err_q;
  logic [RAW_W-1:0]         s7_d1_q;

  assign s7_off_d  = s6_off_q - OFF_W'(s6_off2_q);
  assign s7_sens_d = s6_sens_q - SENS_W'(s6_sens2_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_off_q  <= s7_off_d;
      s7_sens_q <= s7_sens_d;
      s7_temp_q <= s6_temp_q;
      s7_err_q  <= s6_err_q;
      s7_d1_q   <= s6_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: pressure times sensitivity as two partial products
  // --------------------------------------------------------------------------
  logic [LO_W-1:0]          s8_lo_d, s8_lo_q;
  logic signed [HI_W-1:0]   s8_hi_d, s8_hi_q;
  logic signed [OFF_W-1:0]  s8_off_q;
  logic signed [TEMP_W-1:0] s8_temp_q;
  logic                     s8_err_q;

  assign s8_lo_d = LO_W'(s7_d1_q) * LO_W'(s7_sens_q[SPLIT-1:0]);
  assign s8_hi_d = HI_W'($signed({1'b0, s7_d1_q})) * HI_W'($signed(s7_sens_q[SENS_W-1:SPLIT]));

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_lo_q   <= s8_lo_d;
      s8_hi_q   <= s8_hi_d;
      s8_off_q  <= s7_off_q;
      s8_temp_q <= s7_temp_q;
      s8_err_q  <= s7_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: full product
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] s9_prod_d, s9_prod_q;
  logic signed [OFF_W-1:0]  s9_off_q;
  logic signed [TEMP_W-1:0] s9_temp_q;
  logic                     s9_err_q;

  assign s9_prod_d = {s8_hi_q[PROD_W-SPLIT-1:0], {SPLIT{1'b0}}} + PROD_W'(s8_lo_q);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_prod_q <= s9_prod_d;
      s9_off_q  <= s8_off_q;
      s9_temp_q <= s8_temp_q;
      s9_err_q  <= s8_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: pressure and output register
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] s10_diff;
  logic signed [TEMP_W-1:0] s10_temp_d, s10_temp_q;
  logic signed [PRES_W-1:0] s10_pres_d, s10_pres_q;
  logic                     s10_err_q;

  assign s10_diff   = DIFF_W'(s9_prod_q >>> P_SHIFT1) - DIFF_W'(s9_off_q);
  assign s10_pres_d = s9_err_q ? '0 : s10_diff[P_SHIFT2 +: PRES_W];
  assign s10_temp_d = s9_err_q ? '0 : s9_temp_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_temp_q <= s10_temp_d;
      s10_pres_q <= s10_pres_d;
      s10_err_q  <= s9_err_q;
    end
  end

  assign out_if.valid                = v_q[NS];
  assign out_if.temperature_centideg = s10_temp_q;
  assign out_if.pressure_pa          = s10_pres_q;
  assign out_if.sample_error         = s10_err_q;

`ifndef NO_ASSERTIONS
  // A rejected sample carries zero in both result fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.sample_error |->
      out_if.temperature_centideg == '0 && out_if.pressure_pa == '0)
    else $error("rejected sample with non-zero result");

  // The input side only refuses a transfer when every stage holds an item.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> &v_q)
    else $error("input stalled while the pipeline has a bubble");

  // The very-cold correction only ever applies on top of the cold one.
  a_vlow_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && s3_vlow_q |-> s3_low_q)
    else $error("very-low flag without low flag");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Streams raw pressure/temperature pairs through the block under random
// handshake gaps, predicts every compensated reading from a shadow copy of
// the calibration words, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bpc_pkg::*;

  localparam int NUM_REGS    = 6;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centideg;
    logic signed [PRES_W-1:0] pressure_pa;
    logic                     sample_error;
  } reading_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();

  baro_pressure_temperature_compensation dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  cal_t     cal_shadow;
  reading_t expected_readings[$];
  int       failures;
  int       in_max_gap;
  int       out_max_gap;
  int       stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Compensated reading for one raw pair under the given calibration.
  function automatic reading_t compensate(input cal_t c, input logic [RAW_W-1:0] rp,
                                          input logic [RAW_W-1:0] rt);
    longint   dt;
    longint   temp;
    longint   off;
    longint   sens;
    longint   t2;
    longint   off2;
    longint   sens2;
    longint   sq;
    longint   p;
    reading_t r;
    r = '0;
    if (rp == '0 || rp == RAW_ALL_ONES || rt == '0 || rt == RAW_ALL_ONES) begin
      r.sample_error = 1'b1;
      return r;
    end
    dt   = longint'(rt) - (longint'(c.reference_temperature) <<< 8);
    temp = TEMP_REF + ((dt * longint'(c.temperature_coef)) >>> T_SHIFT);
    off  = (longint'(c.pressure_offset) <<< 16)
         + ((dt * longint'(c.offset_temp_coef)) >>> OFF_SHIFT);
    sens = (longint'(c.pressure_sensitivity) <<< 15)
         + ((dt * longint'(c.sensitivity_temp_coef)) >>> SENS_SHIFT);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < TEMP_REF) begin
      t2    = (dt * dt) >>> T2_SHIFT;
      sq    = (temp - TEMP_REF) * (temp - TEMP_REF);
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < TEMP_VERY_LOW) begin
        sq    = (temp - TEMP_VERY_LOW) * (temp - TEMP_VERY_LOW);
        off2  = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
    end
    off  = off - off2;
    sens = sens - sens2;
    temp = temp - t2;
    p    = (((longint'(rp) * sens) >>> P_SHIFT1) - off) >>> P_SHIFT2;
    r.temperature_centideg = temp[TEMP_W-1:0];
    r.pressure_pa          = p[PRES_W-1:0];
    return r;
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input int unsigned idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_REGS) begin
      case (reg_idx_e'(idx))
        REG_PRESS_SENS: cal_shadow.pressure_sensitivity  = value[CAL_W-1:0];
        REG_PRESS_OFS:  cal_shadow.pressure_offset       = value[CAL_W-1:0];
        REG_SENS_TCO:   cal_shadow.sensitivity_temp_coef = value[CAL_W-1:0];
        REG_OFS_TCO:    cal_shadow.offset_temp_coef      = value[CAL_W-1:0];
        REG_TEMP_REF:   cal_shadow.reference_temperature = value[CAL_W-1:0];
        REG_TEMP_COEF:  cal_shadow.temperature_coef      = value[CAL_W-1:0];
        default: ;
      endcase
    end
    @(posedge clk_i);
  endtask

  // The upper half of each word is junk; only the low 16 bits must stick.
  task automatic load_calibration(input cal_t c);
    write_register(REG_PRESS_SENS, {16'($urandom), c.pressure_sensitivity});
    write_register(REG_PRESS_OFS,  {16'($urandom), c.pressure_offset});
    write_register(REG_SENS_TCO,   {16'($urandom), c.sensitivity_temp_coef});
    write_register(REG_OFS_TCO,    {16'($urandom), c.offset_temp_coef});
    write_register(REG_TEMP_REF,   {16'($urandom), c.reference_temperature});
    write_register(REG_TEMP_COEF,  {16'($urandom), c.temperature_coef});
  endtask

  // Meant to be called just after the clock rises; returns once the input side has taken the sample.
  task automatic send_sample(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    expected_readings.push_back(compensate(cal_shadow, rp, rt));
    in_if.valid           <= 1'b1;
    in_if.raw_pressure    <= rp;
    in_if.raw_temperature <= rt;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [CAL_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CAL_W'($urandom);
  endfunction

  function automatic logic [RAW_W-1:0] random_raw_pressure();
    int pick;
    pick = $urandom_range(0, 49);
    if (pick == 0) return '0;
    if (pick == 1) return RAW_ALL_ONES;
    return RAW_W'($urandom);
  endfunction

  // 24 of 50 picks put the temperature near the reference point so that the warm,
  // cold and very cold branches are all well populated.
  function automatic logic [RAW_W-1:0] random_raw_temperature();
    int     pick;
    longint centre;
    pick = $urandom_range(0, 49);
    if (pick == 0) return '0;
    if (pick == 1) return RAW_ALL_ONES;
    if (pick < 26) return RAW_W'($urandom);
    centre = (longint'(cal_shadow.reference_temperature) <<< 8)
           + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    if (centre < 1) centre = 1;
    if (centre > longint'(RAW_ALL_ONES) - 1) centre = longint'(RAW_ALL_ONES) - 1;
    return centre[RAW_W-1:0];
  endfunction

  // Result side: random back-pressure, and a check on every transfer.
  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      $error("result transfer with no sample outstanding");
      failures++;
      return;
    end
    want = expected_readings.pop_front();
    if (out_if.sample_error !== want.sample_error) begin
      $error("sample_error: expected %0d, got %0d", want.sample_error, out_if.sample_error);
      failures++;
    end
    if (out_if.temperature_centideg !== want.temperature_centideg) begin
      $error("temperature_centideg: expected %0d, got %0d",
             want.temperature_centideg, out_if.temperature_centideg);
      failures++;
    end
    if (out_if.pressure_pa !== want.pressure_pa) begin
      $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, out_if.pressure_pa);
      failures++;
    end
  endtask

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, out_max_gap);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_reading();
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Calibration words are all zero straight out of reset.
  task automatic test_reset_defaults();
    send_sample(24'h400000, 24'h800000);
    send_sample(24'h000001, 24'h000001);
    send_sample(24'hFFFFFE, 24'hFFFFFE);
    drain_pipeline();
  endtask

  // Oversized values and writes beyond the last register.
  task automatic test_register_writes();
    cal_t c;
    c = '{pressure_sensitivity: 16'hB000, pressure_offset: 16'h9000,
          sensitivity_temp_coef: 16'h6000, offset_temp_coef: 16'h5C00,
          reference_temperature: 16'h8000, temperature_coef: 16'h8000};
    load_calibration(c);
    write_register(NUM_REGS, $urandom);
    write_register(NUM_REGS + 1, $urandom);
    send_sample(24'h8A0000, 24'h812345);
    send_sample(24'h5A5A5A, 24'h7A5A5A);
    drain_pipeline();
  endtask

  task automatic test_invalid_samples();
    send_sample('0, 24'h800000);
    send_sample(RAW_ALL_ONES, 24'h800000);
    send_sample(24'h800000, '0);
    send_sample(24'h800000, RAW_ALL_ONES);
    send_sample('0, '0);
    send_sample(RAW_ALL_ONES, RAW_ALL_ONES);
    drain_pipeline();
  endtask

  // With the reference at 0x800000 and a coefficient of 0x8000 the first-order
  // temperature is 20.00 degC plus dT / 256, which puts the band edges at
  // exact raw values.
  task automatic test_temperature_bands();
    send_sample(24'h8A0000, 24'h900000);
    send_sample(24'h8A0000, 24'h800000);
    send_sample(24'h8A0000, 24'h7FFFFF);
    send_sample(24'h8A0000, 24'd7492608);
    send_sample(24'h8A0000, 24'd7492607);
    send_sample(24'h8A0000, 24'h000001);
    send_sample(24'h000001, 24'h7A0000);
    send_sample(24'hFFFFFE, 24'h7A0000);
    drain_pipeline();
  endtask

  task automatic test_calibration_extremes();
    load_calibration('1);
    send_sample(24'hFFFFFE, 24'h000001);
    send_sample(24'hFFFFFE, 24'hFFFFFE);
    send_sample(24'h000001, 24'h123456);
    send_sample(24'h800000, 24'hFF0000);
    drain_pipeline();
  endtask

  // Phases with fresh random calibration, the last one all zero; some phases run without gaps.
  task automatic test_random_traffic();
    cal_t c;
    for (int k = 0; k < PHASES; k++) begin
      c.pressure_sensitivity  = random_word();
      c.pressure_offset       = random_word();
      c.sensitivity_temp_coef = random_word();
      c.offset_temp_coef      = random_word();
      c.reference_temperature = random_word();
      c.temperature_coef      = random_word();
      if (k == PHASES - 1) c = '0;
      load_calibration(c);
      in_max_gap  = (k % 3 == 0) ? 0 : 6;
      out_max_gap = (k % 4 == 1) ? 0 : 6;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(random_raw_pressure(), random_raw_temperature());
      end
      drain_pipeline();
    end
  endtask

  initial begin
    failures     = 0;
    stall_cycles = 0;
    in_max_gap   = 6;
    out_max_gap  = 6;
    cal_shadow   = '0;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_if.valid           <= 1'b0;
    in_if.raw_pressure    <= '0;
    in_if.raw_temperature <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_writes();
    test_invalid_samples();
    test_temperature_bands();
    test_calibration_extremes();
    test_random_traffic();

    repeat (NS + 5) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $error("%0d results never arrived", expected_readings.size());
      failures++;
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
